// File: src/assert_macros.svh
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_IMPL(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) pre |=> post) else $error(msg);
`else
`define ASSERT_IMPL(lbl, clk, rst_n, prop, msg)
`define ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg)
`endif
`endif

// File: src/psd_pkg.sv
// Types and constants of the point to segment squared distance pipeline.
package psd_pkg;
    localparam int CoordBits = 24;
    localparam int TFracBits = 24;
    localparam int DiffBits  = CoordBits + 1;
    localparam int ProdBits  = 2 * DiffBits;
    localparam int Ab2Bits   = ProdBits + 1;
    localparam int DotBits   = ProdBits + 2;
    localparam int DBits     = DiffBits + 1;
    localparam int SqBits    = 2 * DBits - 1;
    localparam int SumBits   = SqBits + 2;
    localparam int DistBits  = 50;
    localparam int DivSteps  = TFracBits;

    localparam logic [1:0] RegDegen    = 2'd0;
    localparam logic [1:0] RegClampA   = 2'd1;
    localparam logic [1:0] RegClampB   = 2'd2;
    localparam logic [1:0] RegInterior = 2'd3;

    localparam logic [DistBits-1:0] DistMax = '1;
    localparam logic [DistBits-1:0] RadiusReset = DistBits'(5898);

    typedef logic signed [DiffBits-1:0] t_diff;

    typedef struct packed {
        t_diff [2:0]                     ap;
        t_diff [2:0]                     ab;
        t_diff [2:0]                     bp;
        logic        [2:0][ProdBits-1:0] ab_sq;
        logic signed [2:0][ProdBits-1:0] ap_ab;
        logic signed [DotBits-1:0]       dot;
        logic        [Ab2Bits-1:0]       ab2;
        logic        [Ab2Bits-1:0]       rem;
        logic        [TFracBits-1:0]     tq;
        logic        [1:0]               region;
    } t_item;

    typedef struct packed {
        logic [DistBits-1:0] dist_sq;
        logic                within_res;
        logic [1:0]          region;
    } t_result;
endpackage

// File: src/psd_front.sv
// Front stages: differences, products, sums and region decision.
module psd_front (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [9*psd_pkg::CoordBits-1:0] i_data,
    output logic                        o_valid,
    input  logic                        i_ready,
    output psd_pkg::t_item              o_item
);
    import psd_pkg::*;

    logic  r_va, r_vb, r_vc;
    t_item r_a, r_b, r_c, n_a, n_b, n_c;
    logic  rdy_a, rdy_b, rdy_c;

    assign rdy_c   = !r_vc || i_ready;
    assign rdy_b   = !r_vb || rdy_c;
    assign rdy_a   = !r_va || rdy_b;
    assign o_ready = rdy_a;
    assign o_valid = r_vc;
    assign o_item  = r_c;

    always_comb begin
        logic signed [CoordBits-1:0] p, a, b;
        n_a = '0;
        for (int i = 0; i < 3; i++) begin
            p = i_data[i*CoordBits +: CoordBits];
            a = i_data[(3+i)*CoordBits +: CoordBits];
            b = i_data[(6+i)*CoordBits +: CoordBits];
            n_a.ap[i] = DiffBits'(p) - DiffBits'(a);
            n_a.ab[i] = DiffBits'(b) - DiffBits'(a);
            n_a.bp[i] = DiffBits'(p) - DiffBits'(b);
        end
    end

    always_comb begin
        n_b = r_a;
        for (int i = 0; i < 3; i++) begin
            n_b.ab_sq[i] = ProdBits'($signed(r_a.ab[i]) * $signed(r_a.ab[i]));
            n_b.ap_ab[i] = ProdBits'($signed(r_a.ap[i]) * $signed(r_a.ab[i]));
        end
    end

    always_comb begin
        logic signed [DotBits-1:0] ab2s;
        n_c = r_b;
        n_c.ab2 = Ab2Bits'(r_b.ab_sq[0]) + Ab2Bits'(r_b.ab_sq[1]) + Ab2Bits'(r_b.ab_sq[2]);
        n_c.dot = DotBits'($signed(r_b.ap_ab[0])) + DotBits'($signed(r_b.ap_ab[1]))
                + DotBits'($signed(r_b.ap_ab[2]));
        ab2s = $signed({1'b0, n_c.ab2});
        n_c.rem = '0;
        n_c.tq  = '0;
        priority if (n_c.ab2 == '0) begin
            n_c.region = RegDegen;
        end else if (n_c.dot <= 0) begin
            n_c.region = RegClampA;
        end else if (n_c.dot >= ab2s) begin
            n_c.region = RegClampB;
        end else begin
            n_c.region = RegInterior;
            n_c.rem = n_c.dot[Ab2Bits-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
            r_vb <= 1'b0;
            r_vc <= 1'b0;
        end else begin
            if (rdy_a) r_va <= i_valid;
            if (rdy_b) r_vb <= r_va;
            if (rdy_c) r_vc <= r_vb;
        end
        if (rdy_a) r_a <= n_a;
        if (rdy_b) r_b <= n_b;
        if (rdy_c) r_c <= n_c;
    end
endmodule

// File: src/psd_div_cell.sv
// One restoring division step of the projection quotient.
module psd_div_cell (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  psd_pkg::t_item i_item,
    output logic           o_valid,
    input  logic           i_ready,
    output psd_pkg::t_item o_item
);
    import psd_pkg::*;

    logic  r_v;
    t_item r_item, n_item;
    logic [Ab2Bits:0] rem2;

    assign o_ready = !r_v || i_ready;
    assign o_valid = r_v;
    assign o_item  = r_item;

    always_comb begin
        n_item = i_item;
        rem2 = {i_item.rem, 1'b0};
        if (rem2 >= {1'b0, i_item.ab2}) begin
            n_item.rem = Ab2Bits'(rem2 - {1'b0, i_item.ab2});
            n_item.tq  = {i_item.tq[TFracBits-2:0], 1'b1};
        end else begin
            n_item.rem = rem2[Ab2Bits-1:0];
            n_item.tq  = {i_item.tq[TFracBits-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (o_ready) begin
            r_v <= i_valid;
        end
        if (o_ready) r_item <= n_item;
    end
endmodule

// File: src/psd_back.sv
// Back stages: projected offsets, distance vector, squares and result register.
module psd_back (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    output logic                             o_ready,
    input  psd_pkg::t_item                   i_item,
    input  logic [psd_pkg::DistBits-1:0]     i_radius,
    output logic                             o_valid,
    input  logic                             i_ready,
    output psd_pkg::t_result                 o_res
);
    import psd_pkg::*;

    logic r_vd, r_ve, r_vf, r_vg, r_vh;
    logic rdy_d, rdy_e, rdy_f, rdy_g, rdy_h;
    t_item r_d;
    t_diff [2:0] r_ap_e, r_bp_e;
    logic signed [2:0][DBits-1:0] r_offs, n_offs;
    logic signed [2:0][DBits-1:0] r_dv, n_dv;
    logic [1:0] r_reg_e, r_reg_f, r_reg_g;
    logic [2:0][SqBits-1:0] r_sq, n_sq;
    t_result r_res, n_res;

    assign rdy_h   = !r_vh || i_ready;
    assign rdy_g   = !r_vg || rdy_h;
    assign rdy_f   = !r_vf || rdy_g;
    assign rdy_e   = !r_ve || rdy_f;
    assign rdy_d   = !r_vd || rdy_e;
    assign o_ready = rdy_d;
    assign o_valid = r_vh;
    assign o_res   = r_res;

    always_comb begin
        logic [DiffBits-1:0] m;
        logic [DiffBits+TFracBits-1:0] prod;
        logic [DiffBits-1:0] off;
        for (int i = 0; i < 3; i++) begin
            m    = r_d.ab[i][DiffBits-1] ? DiffBits'(-r_d.ab[i]) : DiffBits'(r_d.ab[i]);
            prod = (DiffBits+TFracBits)'(m) * (DiffBits+TFracBits)'(r_d.tq);
            off  = prod[TFracBits +: DiffBits];
            n_offs[i] = r_d.ab[i][DiffBits-1] ? -$signed({1'b0, off}) : $signed({1'b0, off});
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            unique case (r_reg_e)
                RegClampB:   n_dv[i] = DBits'($signed(r_bp_e[i]));
                RegInterior: n_dv[i] = DBits'($signed(r_ap_e[i])) - r_offs[i];
                default:     n_dv[i] = DBits'($signed(r_ap_e[i]));
            endcase
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_sq[i] = SqBits'($signed(r_dv[i]) * $signed(r_dv[i]));
        end
    end

    always_comb begin
        logic [SumBits-1:0] sum;
        sum = SumBits'(r_sq[0]) + SumBits'(r_sq[1]) + SumBits'(r_sq[2]);
        n_res.region     = r_reg_g;
        n_res.within_res = sum <= SumBits'(i_radius);
        n_res.dist_sq    = (sum > SumBits'(DistMax)) ? DistMax : sum[DistBits-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vd <= 1'b0;
            r_ve <= 1'b0;
            r_vf <= 1'b0;
            r_vg <= 1'b0;
            r_vh <= 1'b0;
        end else begin
            if (rdy_d) r_vd <= i_valid;
            if (rdy_e) r_ve <= r_vd;
            if (rdy_f) r_vf <= r_ve;
            if (rdy_g) r_vg <= r_vf;
            if (rdy_h) r_vh <= r_vg;
        end
        if (rdy_d) r_d <= i_item;
        if (rdy_e) begin
            r_offs  <= n_offs;
            r_ap_e  <= r_d.ap;
            r_bp_e  <= r_d.bp;
            r_reg_e <= r_d.region;
        end
        if (rdy_f) begin
            r_dv    <= n_dv;
            r_reg_f <= r_reg_e;
        end
        if (rdy_g) begin
            r_sq    <= n_sq;
            r_reg_g <= r_reg_f;
        end
        if (rdy_h) r_res <= n_res;
    end
endmodule

// File: src/point_segment_distance_squared.sv
// Top level of the point to segment squared distance block.
//
// Channel   Direction  tdata / tuser contents
// s_*       in         tdata: px, py, pz, ax, ay, az, bx, by_coord, bz (24 bits each)
// m_*       out        tdata: dist_sq (50 bits); tuser: within_res, region
// APB       config     radius_squared at byte address 0
//
// One transfer is accepted per cycle while the output is not stalled; the pipeline has 3 front stages,
// 24 division cells and 5 back stages including the output register.
// The 24-cell division chain is the longest part of the pipeline; every stage holds when the next is full.
// Reset is synchronous, clears the stage valid flags and sets radius_squared to RadiusReset.
// A stalled output blocks only the stages behind it until bubbles fill up.
module point_segment_distance_squared (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [215:0] s_tdata,   // px, py, pz, ax, ay, az, bx, by_coord, bz
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [55:0]  m_tdata,   // dist_sq, zero fill
    output logic [2:0]   m_tuser,   // within_res, region
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [3:0]   paddr,
    input  logic [63:0]  pwdata,
    output logic [63:0]  prdata,
    output logic         pready
);
    import psd_pkg::*;
    `include "assert_macros.svh"

    logic [DistBits-1:0] r_radius;
    logic    f_valid;
    t_item   f_item;
    logic    [DivSteps:0] c_valid, c_ready;
    t_item   [DivSteps:0] c_item;
    t_result res;

    assign pready = 1'b1;
    assign prdata = (paddr == 4'd0) ? 64'(r_radius) : 64'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius <= RadiusReset;
        end else if (psel && penable && pwrite && paddr == 4'd0) begin
            r_radius <= pwdata[DistBits-1:0];
        end
    end

    psd_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(s_tvalid), .o_ready(s_tready), .i_data(s_tdata),
        .o_valid(c_valid[0]), .i_ready(c_ready[0]), .o_item(c_item[0])
    );

    for (genvar g = 0; g < DivSteps; g++) begin : g_div
        psd_div_cell u_cell (
            .i_clk(i_clk), .i_rst_n(i_rst_n),
            .i_valid(c_valid[g]), .o_ready(c_ready[g]), .i_item(c_item[g]),
            .o_valid(c_valid[g+1]), .i_ready(c_ready[g+1]), .o_item(c_item[g+1])
        );
    end

    assign f_valid = c_valid[DivSteps];
    assign f_item  = c_item[DivSteps];

    psd_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(f_valid), .o_ready(c_ready[DivSteps]), .i_item(f_item),
        .i_radius(r_radius),
        .o_valid(m_tvalid), .i_ready(m_tready), .o_res(res)
    );

    assign m_tdata = 56'(res.dist_sq);
    assign m_tuser = {res.region, res.within_res};

    `ASSERT_IMPL(a_within, i_clk, i_rst_n, (m_tvalid && res.within_res) |-> (res.dist_sq <= r_radius), "within above radius")
    `ASSERT_IMPL(a_sat, i_clk, i_rst_n, (m_tvalid && res.within_res && res.dist_sq == DistMax) |-> (r_radius == DistMax), "saturated within")
    `ASSERT_NEXT(a_hold, i_clk, i_rst_n, (m_tvalid && !m_tready), (m_tvalid && $stable(m_tdata)), "stalled result changed")
endmodule
